[hdl/rmsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Relative motion to scroll converter: shared package
// Field widths, event codes, register indexes, and the types that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rmsc_pkg;

  // Field widths.
  localparam int TYPE_W  = 5;
  localparam int CODE_W  = 10;
  localparam int VALUE_W = 32;
  localparam int DIV_W   = 15;
  localparam int REM_W   = 16;
  localparam int SUM_W   = VALUE_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIV_W;

  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_DIVISOR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_DIVISOR    = 2'd2;

  // Event types and codes.
  localparam logic [TYPE_W-1:0] TYPE_SYNC = 5'd0;
  localparam logic [TYPE_W-1:0] TYPE_KEY  = 5'd1;
  localparam logic [TYPE_W-1:0] TYPE_REL  = 5'd2;

  localparam logic [CODE_W-1:0] AXIS_X      = 10'd0;
  localparam logic [CODE_W-1:0] AXIS_Y      = 10'd1;
  localparam logic [CODE_W-1:0] CODE_HWHEEL = 10'd6;
  localparam logic [CODE_W-1:0] CODE_WHEEL  = 10'd8;

  // Divider: one quotient bit per cycle over the magnitude of the sum.
  localparam int DIV_STEPS = VALUE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLASSIFY,
    S_DIVIDE,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    CLS_PASS,
    CLS_DROP_SYNC,
    CLS_TRIGGER,
    CLS_SCROLL
  } class_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic capture;
    logic start_div;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    class_t cls;
    logic   div_busy;
    logic   div_last;
    logic   emit_blocked;
  } stat_t;

endpackage : rmsc_pkg
`default_nettype wire

[hdl/rmsc_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Relative motion to scroll converter: channel interfaces
// Valid/ready channels for incoming events and for result events.
// ----------------------------------------------------------------------------
interface rmsc_in_if;
  import rmsc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [TYPE_W-1:0]        ev_type;
  logic [CODE_W-1:0]        ev_code;
  logic signed [VALUE_W-1:0] ev_value;

  modport source (output valid, output ev_type, output ev_code, output ev_value,
                  input ready);
  modport sink (input valid, input ev_type, input ev_code, input ev_value,
                output ready);
endinterface : rmsc_in_if

interface rmsc_out_if;
  import rmsc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [TYPE_W-1:0]        out_type;
  logic [CODE_W-1:0]        out_code;
  logic signed [VALUE_W-1:0] out_value;

  modport source (output valid, output out_type, output out_code, output out_value,
                  input ready);
  modport sink (input valid, input out_type, input out_code, input out_value,
                output ready);
endinterface : rmsc_out_if
`default_nettype wire

[hdl/rmsc_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Relative motion to scroll converter: iterative divider
// Unsigned restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmsc_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [rmsc_pkg::VALUE_W-1:0]  dividend,
  input  wire logic [rmsc_pkg::DIV_W-1:0]    divisor,
  output logic                               busy,
  output logic                               last,
  output logic [rmsc_pkg::VALUE_W-1:0]       quotient,
  output logic [rmsc_pkg::DIV_W-1:0]         remainder
);
  import rmsc_pkg::*;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_W:0]       shifted;
  logic [DIV_W+1:0]     diff;
  logic                 fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    shifted = {remainder, quotient[VALUE_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
    fits    = ~diff[DIV_W+1];
  end

  assign last = busy && (cnt == CNT_LAST);

  // Control of the step count.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      busy <= !last;
      cnt  <= cnt + 1'b1;
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      dvs       <= divisor;
      remainder <= '0;
      quotient  <= dividend;
    end else if (busy) begin
      remainder <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quotient  <= {quotient[VALUE_W-2:0], fits};
    end
  end

endmodule : rmsc_div
`default_nettype wire

[hdl/rmsc_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Relative motion to scroll converter: controller
// Steps each item through capture, classification, division (scroll items only) and commit.
// ----------------------------------------------------------------------------
module rmsc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire rmsc_pkg::stat_t  stat,
  output rmsc_pkg::cmd_t        cmd,
  output rmsc_pkg::state_t      state
);
  import rmsc_pkg::*;

  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CLASSIFY;
      end
      S_CLASSIFY: begin
        state_next = (stat.cls == CLS_SCROLL) ? S_DIVIDE : S_EMIT;
      end
      S_DIVIDE: begin
        if (stat.div_last) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.emit_blocked) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Commands.
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.capture  = in_valid;
      end
      S_CLASSIFY: begin
        cmd.start_div = (stat.cls == CLS_SCROLL);
      end
      S_DIVIDE: begin
        cmd = '0;
      end
      S_EMIT: begin
        cmd.commit = !stat.emit_blocked;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule : rmsc_ctrl
`default_nettype wire

[hdl/rmsc_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Relative motion to scroll converter: datapath
// Configuration and mode registers, per-axis remainders, the divider and the
// result register.
// ----------------------------------------------------------------------------
module rmsc_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [rmsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rmsc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire rmsc_pkg::cmd_t                       cmd,
  output rmsc_pkg::stat_t                           stat,
  input  wire logic [rmsc_pkg::TYPE_W-1:0]          ev_type,
  input  wire logic [rmsc_pkg::CODE_W-1:0]          ev_code,
  input  wire logic signed [rmsc_pkg::VALUE_W-1:0]  ev_value,
  input  wire logic                                 out_ready,
  output logic                                      out_valid,
  output logic [rmsc_pkg::TYPE_W-1:0]               out_type,
  output logic [rmsc_pkg::CODE_W-1:0]               out_code,
  output logic signed [rmsc_pkg::VALUE_W-1:0]       out_value
);
  import rmsc_pkg::*;

  localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  // Configuration and mode state.
  logic [CODE_W-1:0]       trigger_code;
  logic [DIV_W-1:0]        x_divisor;
  logic [DIV_W-1:0]        y_divisor;
  logic                    scroll_mode;
  logic                    drop_next_sync;
  logic signed [REM_W-1:0] x_remainder;
  logic signed [REM_W-1:0] y_remainder;

  // Captured item.
  logic [TYPE_W-1:0]        it_type;
  logic [CODE_W-1:0]        it_code;
  logic [VALUE_W-1:0]       it_value;
  logic signed [SUM_W-1:0]  sum;

  // Working signals.
  logic signed [REM_W-1:0] rem_in;
  logic [SUM_W-1:0]        sum_abs;
  logic [DIV_W-1:0]        div_sel;
  logic                    div_busy;
  logic                    div_last;
  logic [VALUE_W-1:0]      quo;
  logic [DIV_W-1:0]        rem_mag;
  logic                    quo_zero;
  logic                    has_result;
  logic [VALUE_W-1:0]      sat_value;
  logic [REM_W-1:0]        rem_new;
  logic                    is_y;
  class_t                  cls;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_code <= '0;
      x_divisor    <= DIV_W'(1);
      y_divisor    <= DIV_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TRIGGER_CODE: trigger_code <= cfg_data[CODE_W-1:0];
        REG_X_DIVISOR:    x_divisor    <= cfg_data;
        REG_Y_DIVISOR:    y_divisor    <= cfg_data;
        default:          trigger_code <= trigger_code;
      endcase
    end
  end

  // Capture the item and add the remainder of the addressed axis.
  assign rem_in = (ev_code == AXIS_Y) ? y_remainder : x_remainder;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_type  <= ev_type;
      it_code  <= ev_code;
      it_value <= ev_value;
      sum      <= SUM_W'(rem_in) + SUM_W'(ev_value);
    end
  end

  // Classify the captured item against the current mode.
  assign is_y = (it_code == AXIS_Y);

  always_comb begin
    if (it_type == TYPE_SYNC && drop_next_sync) begin
      cls = CLS_DROP_SYNC;
    end else if (it_type == TYPE_KEY && it_code == trigger_code) begin
      cls = CLS_TRIGGER;
    end else if (scroll_mode && it_type == TYPE_REL &&
                 (it_code == AXIS_X || it_code == AXIS_Y)) begin
      cls = CLS_SCROLL;
    end else begin
      cls = CLS_PASS;
    end
  end

  // Divider operands: magnitude of the sum, zero divisor treated as one.
  always_comb begin
    sum_abs = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    div_sel = is_y ? y_divisor : x_divisor;
    if (div_sel == '0) div_sel = DIV_W'(1);
  end

  rmsc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.start_div),
    .dividend  (sum_abs[VALUE_W-1:0]),
    .divisor   (div_sel),
    .busy      (div_busy),
    .last      (div_last),
    .quotient  (quo),
    .remainder (rem_mag)
  );

  // Signed quotient with saturation, and the signed remainder.
  always_comb begin
    quo_zero = (quo == '0);
    if (sum[SUM_W-1]) begin
      sat_value = (quo > VAL_MIN) ? VAL_MIN : VALUE_W'(-quo);
      rem_new   = REM_W'(-{1'b0, rem_mag});
    end else begin
      sat_value = quo[VALUE_W-1] ? VAL_MAX : quo;
      rem_new   = {1'b0, rem_mag};
    end
    has_result = (cls == CLS_PASS) || (cls == CLS_SCROLL && !quo_zero);
  end

  assign stat.cls          = cls;
  assign stat.div_busy     = div_busy;
  assign stat.div_last     = div_last;
  assign stat.emit_blocked = has_result && out_valid && !out_ready;

  // Mode, drop flag and remainder updates at commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_mode    <= 1'b0;
      drop_next_sync <= 1'b0;
      x_remainder    <= '0;
      y_remainder    <= '0;
    end else if (cmd.commit) begin
      drop_next_sync <= (cls == CLS_TRIGGER) || (cls == CLS_SCROLL && quo_zero);
      if (cls == CLS_TRIGGER) scroll_mode <= (it_value != '0);
      if (cls == CLS_SCROLL) begin
        if (is_y) y_remainder <= rem_new;
        else x_remainder <= rem_new;
      end
    end
  end

  // Result register: it holds one item until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && has_result) begin
      out_type <= it_type;
      if (cls == CLS_SCROLL) begin
        out_code  <= is_y ? CODE_WHEEL : CODE_HWHEEL;
        out_value <= sat_value;
      end else begin
        out_code  <= it_code;
        out_value <= it_value;
      end
    end
  end

endmodule : rmsc_datapath
`default_nettype wire

[hdl/rel_motion_to_scroll_converter_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Relative motion to scroll converter: top level
// Turns relative pointer motion into wheel events while scroll mode is on.
// ----------------------------------------------------------------------------
// ev_in carries one input event per item (type, code, signed value); ev_out
// carries at most one result event per input item. Both are valid/ready.
// The configuration port writes trigger_code, x_divisor or y_divisor on any
// cycle with cfg_wr_en high; write it only while no item is in flight.
// Passed, swallowed and trigger items go through accept, classify and emit;
// scroll-mode X/Y motion also passes the divide state, where the shared
// restoring divider produces one quotient bit per cycle over the 32-bit
// magnitude of remainder plus motion. The next item is accepted only in idle.
// A result appears on ev_out the cycle after the item completes.
// rst (synchronous) sets pointer mode, clears both remainders and the
// sync-drop flag, and loads trigger code 0 and divisors of 1.
// A result waits in the output register while ev_out.ready is low; the
// block still accepts and works on the next item and holds only at the
// point where that item needs the output register.
// ----------------------------------------------------------------------------
module rel_motion_to_scroll_converter_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic [rmsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rmsc_pkg::CFG_DATA_W-1:0]    cfg_data,
  rmsc_in_if.sink                                 ev_in,
  rmsc_out_if.source                              ev_out
);
  import rmsc_pkg::*;

  cmd_t   cmd;
  stat_t  stat;
  state_t state;

  // Sequencer.
  rmsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ev_in.valid),
    .stat     (stat),
    .cmd      (cmd),
    .state    (state)
  );

  assign ev_in.ready = cmd.in_ready;

  // Datapath.
  rmsc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .ev_type   (ev_in.ev_type),
    .ev_code   (ev_in.ev_code),
    .ev_value  (ev_in.ev_value),
    .out_ready (ev_out.ready),
    .out_valid (ev_out.valid),
    .out_type  (ev_out.out_type),
    .out_code  (ev_out.out_code),
    .out_value (ev_out.out_value)
  );

`ifndef SYNTHESIS
  // The divider is busy whenever the sequencer waits for it.
  a_div_busy_in_divide: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVIDE) |-> stat.div_busy)
    else $error("divider idle while waiting for a quotient");

  // An accepted item is classified in the following cycle.
  a_accept_then_classify: assert property (@(posedge clk) disable iff (rst)
    (ev_in.valid && ev_in.ready) |=> (state == S_CLASSIFY))
    else $error("accepted item not classified next cycle");

  // A commit never overwrites a result that the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && ev_out.valid && !ev_out.ready) |=> $stable(ev_out.out_value))
    else $error("pending result overwritten");
`endif

endmodule : rel_motion_to_scroll_converter_unit
`default_nettype wire

[dv/tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Relative motion to scroll converter: testbench
// Sends input events through the ev_in channel and checks every event that
// leaves ev_out against a predictor kept inside this bench. Directed tests
// cover pass-through, the trigger key, sync dropping, division, saturation
// and back-pressure. A long random run follows under several register
// settings and with both channels idling at random.
// ----------------------------------------------------------------------------
module tb;
  import rmsc_pkg::*;

  typedef struct packed {
    logic [TYPE_W-1:0]         kind;
    logic [CODE_W-1:0]         code;
    logic signed [VALUE_W-1:0] value;
  } hid_event_t;

  typedef enum int {
    TRAFFIC_FULL,
    TRAFFIC_SEND_IDLE,
    TRAFFIC_RECV_STALL,
    TRAFFIC_BOTH
  } traffic_t;

  localparam int DRAIN_CYCLES = 40;
  localparam int DRAIN_LIMIT  = 50000;
  localparam int HOLD_CYCLES  = 400;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rmsc_in_if  ev_in_ch ();
  rmsc_out_if ev_out_ch ();

  rel_motion_to_scroll_converter_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ev_in     (ev_in_ch),
    .ev_out    (ev_out_ch)
  );

  // Predictor state and its copy of the registers.
  logic [CODE_W-1:0] trig_code;
  logic [DIV_W-1:0]  x_div;
  logic [DIV_W-1:0]  y_div;
  bit                scroll_on;
  bit                sync_drop_armed;
  longint            x_residue;
  longint            y_residue;

  hid_event_t pending_events[$];
  int         fail_count;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         hold_left;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Work out the event that one input item causes, if any, and advance state.
  function automatic bit convert_event(input hid_event_t ev, output hid_event_t res);
    longint divisor;
    longint total;
    longint quot;
    bit     on_x;
    res = ev;
    if (ev.kind == TYPE_SYNC && sync_drop_armed) begin
      sync_drop_armed = 1'b0;
      return 1'b0;
    end
    sync_drop_armed = 1'b0;
    if (ev.kind == TYPE_KEY && ev.code == trig_code) begin
      scroll_on = (ev.value != 0);
      sync_drop_armed = 1'b1;
      return 1'b0;
    end
    if (scroll_on && ev.kind == TYPE_REL && (ev.code == AXIS_X || ev.code == AXIS_Y)) begin
      on_x = (ev.code == AXIS_X);
      divisor = on_x ? x_div : y_div;
      if (divisor == 0) divisor = 1;
      total = (on_x ? x_residue : y_residue) + longint'($signed(ev.value));
      quot = total / divisor;
      if (quot == 0) begin
        if (on_x) x_residue = total;
        else y_residue = total;
        sync_drop_armed = 1'b1;
        return 1'b0;
      end
      if (on_x) x_residue = total % divisor;
      else y_residue = total % divisor;
      if (quot > 64'sd2147483647) quot = 64'sd2147483647;
      if (quot < -64'sd2147483648) quot = -64'sd2147483648;
      res.code = on_x ? CODE_HWHEEL : CODE_WHEEL;
      res.value = quot[VALUE_W-1:0];
    end
    return 1'b1;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Result checker: each accepted item is matched against the oldest prediction.
  always @(posedge clk) begin
    hid_event_t got;
    hid_event_t want;
    if (!rst && ev_out_ch.valid === 1'b1 && ev_out_ch.ready === 1'b1) begin
      got = '{ev_out_ch.out_type, ev_out_ch.out_code, ev_out_ch.out_value};
      if (pending_events.size() == 0) begin
        note_failure($sformatf("unexpected result: type %0d code %0d value %0d",
                               got.kind, got.code, got.value));
      end else begin
        want = pending_events.pop_front();
        if (got.kind !== want.kind || got.code !== want.code || got.value !== want.value) begin
          note_failure($sformatf(
            "mismatch: expected type %0d code %0d value %0d, got type %0d code %0d value %0d",
            want.kind, want.code, want.value, got.kind, got.code, got.value));
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    ev_out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    if (hold_left > 0) hold_left--;
  end

  task automatic set_traffic(input traffic_t mode);
    case (mode)
      TRAFFIC_FULL: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      TRAFFIC_SEND_IDLE: begin
        send_idle_pct = 66;
        recv_stall_pct = 0;
      end
      TRAFFIC_RECV_STALL: begin
        send_idle_pct = 0;
        recv_stall_pct = 66;
      end
      default: begin
        send_idle_pct = 24;
        recv_stall_pct = 24;
      end
    endcase
  endtask

  // Offer one item and wait until it is accepted; returns in the accepting step.
  task automatic send_event(input logic [TYPE_W-1:0] kind, input logic [CODE_W-1:0] code,
                            input logic [VALUE_W-1:0] value);
    int         gap;
    hid_event_t ev;
    hid_event_t res;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct)
      gap = ($urandom_range(7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 4);
    @(negedge clk);
    repeat (gap) begin
      ev_in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    ev_in_ch.ev_type <= kind;
    ev_in_ch.ev_code <= code;
    ev_in_ch.ev_value <= value;
    ev_in_ch.valid <= 1'b1;
    do @(posedge clk); while (ev_in_ch.ready !== 1'b1);
    ev = '{kind, code, value};
    if (convert_event(ev, res)) pending_events.push_back(res);
  endtask

  // Stop offering items and wait until every predicted result has arrived.
  task automatic wait_drain();
    int waited;
    waited = 0;
    @(negedge clk);
    ev_in_ch.valid <= 1'b0;
    while (pending_events.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_events.size() > 0) begin
      note_failure($sformatf("%0d expected results never arrived", pending_events.size()));
      pending_events.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_TRIGGER_CODE: trig_code = data[CODE_W-1:0];
      REG_X_DIVISOR:    x_div = data;
      REG_Y_DIVISOR:    y_div = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Pointer mode: everything, relative motion included, passes unchanged.
  task automatic test_pass_through();
    set_traffic(TRAFFIC_FULL);
    send_event(TYPE_SYNC, 10'd0, 32'd0);
    send_event(5'd31, 10'd767, 32'h7fffffff);
    send_event(5'd3, 10'd0, 32'h80000000);
    send_event(TYPE_REL, AXIS_X, 32'hffffffff);
    send_event(TYPE_KEY, 10'd767, 32'd1);
    wait_drain();
  endtask

  // Trigger key sets scroll mode from its value in either mode; the next sync is dropped
  // unless some other event comes in between.
  task automatic test_trigger_and_sync();
    set_traffic(TRAFFIC_SEND_IDLE);
    send_event(TYPE_KEY, 10'd0, 32'd1);
    send_event(TYPE_SYNC, 10'd0, 32'd0);
    send_event(TYPE_SYNC, 10'd0, 32'd0);
    send_event(TYPE_KEY, 10'd0, 32'h80000000);
    send_event(TYPE_KEY, 10'd5, 32'd0);
    send_event(TYPE_SYNC, 10'd0, 32'd0);
    send_event(TYPE_KEY, 10'd0, 32'd0);
    wait_drain();
  endtask

  // Division with truncation toward zero, signed remainders, other axes,
  // the largest divisor, a zero divisor and quotient saturation.
  task automatic test_scroll_division();
    set_traffic(TRAFFIC_RECV_STALL);
    write_setting(REG_TRIGGER_CODE, 15'd767);
    write_setting(REG_X_DIVISOR, 15'd3);
    write_setting(REG_Y_DIVISOR, 15'd32767);
    send_event(TYPE_KEY, 10'd767, 32'hffffffff);
    send_event(TYPE_REL, AXIS_X, 32'd2);
    send_event(TYPE_SYNC, 10'd0, 32'd0);
    send_event(TYPE_REL, AXIS_X, 32'd1);
    send_event(TYPE_REL, AXIS_X, -32'sd7);
    send_event(TYPE_REL, AXIS_Y, -32'sd98306);
    send_event(TYPE_REL, 10'd2, 32'd9);
    send_event(TYPE_REL, 10'd767, -32'sd9);
    send_event(TYPE_REL, AXIS_Y, 32'd32766);
    wait_drain();
    // Large residues left from the big divisor push the quotient past the signed 32-bit range.
    write_setting(REG_X_DIVISOR, 15'd32767);
    write_setting(REG_Y_DIVISOR, 15'd1);
    send_event(TYPE_REL, AXIS_X, -32'sd32000);
    send_event(TYPE_REL, AXIS_Y, 32'h7fffffff);
    wait_drain();
    write_setting(REG_X_DIVISOR, 15'd0);
    send_event(TYPE_REL, AXIS_X, 32'h80000000);
    send_event(TYPE_REL, AXIS_X, 32'd5);
    wait_drain();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_back_pressure();
    set_traffic(TRAFFIC_FULL);
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) begin
      case (i % 3)
        0: send_event(TYPE_REL, AXIS_X, 32'(i - 12));
        1: send_event(TYPE_SYNC, 10'd0, 32'(i));
        default: send_event(5'd4, 10'(i), $urandom);
      endcase
    end
    wait_drain();
  endtask

  function automatic logic [VALUE_W-1:0] pick_motion();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return 32'(int'($urandom_range(128)) - 64);
      6, 7: return 32'(int'($urandom_range(80000)) - 40000);
      8: return $urandom;
      default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_divisor();
    case ($urandom_range(9))
      0: return 15'd0;
      1, 2, 3, 4, 5: return 15'($urandom_range(1, 8));
      6, 7, 8: return 15'($urandom_range(1, 32767));
      default: return 15'd32767;
    endcase
  endfunction

  // Random phases: scroll-mode motion and sync events most often, with trigger
  // key events, other keys, other axes and arbitrary events mixed in.
  task automatic test_random_traffic();
    logic [VALUE_W-1:0] key_val;
    for (int phase = 0; phase < 6; phase++) begin
      set_traffic(traffic_t'(phase % 4));
      write_setting(REG_TRIGGER_CODE, (phase == 0) ? 15'd0 : 15'($urandom_range(767)));
      write_setting(REG_X_DIVISOR,
                    (phase == 0) ? 15'd1 : (phase == 1) ? 15'd32767 : pick_divisor());
      write_setting(REG_Y_DIVISOR,
                    (phase == 0) ? 15'd1 : (phase == 1) ? 15'd32767 : pick_divisor());
      send_event(TYPE_KEY, trig_code, 32'd1);
      for (int n = 0; n < 150; n++) begin
        case ($urandom_range(99)) inside
          [0:44]: send_event(TYPE_REL, $urandom_range(1) ? AXIS_Y : AXIS_X, pick_motion());
          [45:64]: send_event(TYPE_SYNC, 10'($urandom_range(767)), $urandom);
          [65:72]: begin
            key_val = ($urandom_range(9) < 7) ? ($urandom_range(1) ? 32'd1 : $urandom) : 32'd0;
            send_event(TYPE_KEY, trig_code, key_val);
          end
          [73:82]: send_event(TYPE_KEY, 10'($urandom_range(767)), $urandom);
          [83:89]: send_event(TYPE_REL, 10'($urandom_range(767)), pick_motion());
          default: send_event(5'($urandom_range(31)), 10'($urandom_range(767)), $urandom);
        endcase
      end
      wait_drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    ev_in_ch.valid = 1'b0;
    ev_in_ch.ev_type = '0;
    ev_in_ch.ev_code = '0;
    ev_in_ch.ev_value = '0;
    ev_out_ch.ready = 1'b0;
    trig_code = '0;
    x_div = 15'd1;
    y_div = 15'd1;
    scroll_on = 1'b0;
    sync_drop_armed = 1'b0;
    x_residue = 0;
    y_residue = 0;
    fail_count = 0;
    hold_left = 0;
    set_traffic(TRAFFIC_FULL);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_pass_through();
    test_trigger_and_sync();
    test_scroll_division();
    test_back_pressure();
    test_random_traffic();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule : tb
`default_nettype wire

[filelist.f]
hdl/rmsc_pkg.sv
hdl/rmsc_ifs.sv
hdl/rmsc_div.sv
hdl/rmsc_ctrl.sv
hdl/rmsc_datapath.sv
hdl/rel_motion_to_scroll_converter_unit.sv
dv/tb.sv
